@@ rtl/ads_pkg.sv @@
// Package for the area-average downscaler: field widths, default maxima,
// register indexes, reset values, controller state type and channel sum
// word type and pixel type. No dependencies.
package ads_pkg;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 32;
    localparam int OUT_COL_W   = 10;
    localparam int OUT_ROW_W   = 12;
    localparam int SRC_W_BITS  = 13;
    localparam int SRC_H_BITS  = 13;
    localparam int DST_W_BITS  = 11;
    localparam int DST_H_BITS  = 12;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 13;

    localparam int DEF_MAX_SRC_WIDTH  = 4096;
    localparam int DEF_MAX_SRC_HEIGHT = 4096;
    localparam int DEF_MAX_DST_WIDTH  = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = CFG_IDX_W'(3);

    localparam logic [SRC_W_BITS-1:0] RST_SRC_WIDTH  = SRC_W_BITS'(200);
    localparam logic [SRC_H_BITS-1:0] RST_SRC_HEIGHT = SRC_H_BITS'(200);
    localparam logic [DST_W_BITS-1:0] RST_DST_WIDTH  = DST_W_BITS'(100);
    localparam logic [DST_H_BITS-1:0] RST_DST_HEIGHT = DST_H_BITS'(100);

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix;

    typedef enum logic [2:0] {
        S_CLAMP,
        S_INIT_C,
        S_INIT_R,
        S_IDLE,
        S_MOD,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

@@ rtl/ads_sum_mem.sv @@
// Column sum memory with read-modify-write: one red/green/blue sum word per
// destination column. Depends on ads_pkg.
module ads_sum_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_addr,
    input  ads_pkg::t_pix   i_pix,
    input  logic            i_first,
    input  logic            i_wr_en,
    output ads_pkg::t_sums  o_sum
);
    import ads_pkg::*;

    t_sums             r_mem [DEPTH];
    t_sums             r_rdata;
    logic [AW-1:0]     r_addr;
    t_pix              r_pix;
    logic              r_first;
    t_sums             n_sum;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
            r_addr  <= i_addr;
            r_pix   <= i_pix;
            r_first <= i_first;
        end
        if (i_wr_en) begin
            r_mem[r_addr] <= n_sum;
        end
    end

    // first row of a band overwrites, later rows accumulate
    always_comb begin
        if (r_first) begin
            n_sum.red   = SUM_W'(r_pix.red);
            n_sum.green = SUM_W'(r_pix.green);
            n_sum.blue  = SUM_W'(r_pix.blue);
        end else begin
            n_sum.red   = r_rdata.red   + SUM_W'(r_pix.red);
            n_sum.green = r_rdata.green + SUM_W'(r_pix.green);
            n_sum.blue  = r_rdata.blue  + SUM_W'(r_pix.blue);
        end
    end

    assign o_sum = n_sum;

endmodule

@@ rtl/ads_div.sv @@
// Three-lane restoring divider, one quotient bit per lane per cycle.
// Shared by bin averaging and boundary setup. Depends on ads_pkg.
module ads_div #(
    parameter int CNT_W = 26,
    parameter int QW    = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ads_pkg::t_sums   i_dvd,
    input  logic [CNT_W-1:0] i_dvs,
    output logic             o_done,
    output logic [QW-1:0]    o_quo [3],
    output logic [CNT_W-1:0] o_rem0
);
    import ads_pkg::*;

    localparam int STEPS = SUM_W;
    localparam int SC_W  = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [SC_W-1:0]  r_cnt;
    logic [CNT_W-1:0] r_dvs;
    logic [SUM_W-1:0] r_dvd [3];
    logic [CNT_W-1:0] r_rem [3];
    logic [QW-1:0]    r_quo [3];
    logic [CNT_W-1:0] n_rem [3];
    logic             n_bit [3];
    logic [SUM_W-1:0] w_dvd [3];

    assign w_dvd[0] = i_dvd.red;
    assign w_dvd[1] = i_dvd.green;
    assign w_dvd[2] = i_dvd.blue;

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [CNT_W:0] w_try;
        logic [CNT_W:0] w_diff;
        assign w_try  = {r_rem[l], r_dvd[l][SUM_W-1]};
        assign w_diff = w_try - {1'b0, r_dvs};
        assign n_bit[l] = (w_try >= {1'b0, r_dvs});
        assign n_rem[l] = n_bit[l] ? w_diff[CNT_W-1:0] : w_try[CNT_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_dvd[l] <= w_dvd[l];
                r_rem[l] <= '0;
                r_quo[l] <= '0;
            end else if (r_busy) begin
                r_dvd[l] <= {r_dvd[l][SUM_W-2:0], 1'b0};
                r_rem[l] <= n_rem[l];
                r_quo[l] <= {r_quo[l][QW-2:0], n_bit[l]};
            end
        end

        assign o_quo[l] = r_quo[l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SC_W'(STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_dvs;
        end
    end

    assign o_done = r_done;
    assign o_rem0 = r_rem[0];

endmodule

@@ rtl/area_average_downscaler.sv @@
// Area-average downscaler: top level with frame position tracking, bin
// boundaries, sum memory and divider. Depends on ads_pkg, ads_sum_mem, ads_div.
//
// Source pixels arrive in raster order; each destination column keeps a
// red/green/blue sum in a single-port-style memory that is read when a pixel
// is taken and written back the next cycle, before another pixel is taken. When
// a pixel closes a bin on the last row of its band, the three sums go through
// a bit-serial divider and the result word is loaded into the output register.
// After reset and after every write to a known register the block computes
// its first boundaries with the same divider before it takes pixels; any such
// write restarts the frame at the top left pixel.
module area_average_downscaler #(
    parameter int MAX_SRC_WIDTH  = ads_pkg::DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = ads_pkg::DEF_MAX_SRC_HEIGHT,
    parameter int MAX_DST_WIDTH  = ads_pkg::DEF_MAX_DST_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ads_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ads_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ads_pkg::PIX_W-1:0]           i_pix_red,
    input  logic [ads_pkg::PIX_W-1:0]           i_pix_green,
    input  logic [ads_pkg::PIX_W-1:0]           i_pix_blue,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ads_pkg::PIX_W-1:0]           o_avg_red,
    output logic [ads_pkg::PIX_W-1:0]           o_avg_green,
    output logic [ads_pkg::PIX_W-1:0]           o_avg_blue,
    output logic [ads_pkg::OUT_COL_W-1:0]       o_out_col,
    output logic [ads_pkg::OUT_ROW_W-1:0]       o_out_row,
    output logic                                o_frame_end
);
    import ads_pkg::*;

    localparam int CW    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int RW    = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DWW   = $clog2(MAX_DST_WIDTH + 1);
    localparam int AW    = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int CNT_W = CW + RW;
    localparam int QW0   = (CW > RW) ? CW : RW;
    localparam int QW    = (QW0 > PIX_W) ? QW0 : PIX_W;

    // configuration and effective dimensions
    logic [SRC_W_BITS-1:0] r_src_width;
    logic [SRC_H_BITS-1:0] r_src_height;
    logic [DST_W_BITS-1:0] r_dst_width;
    logic [DST_H_BITS-1:0] r_dst_height;
    logic [CW-1:0]  r_sw, c_sw;
    logic [RW-1:0]  r_sh, c_sh;
    logic [DWW-1:0] r_dw, c_dw;
    logic [RW-1:0]  r_dh, c_dh;

    // boundary steps
    logic [CW-1:0]  r_col_q;
    logic [DWW-1:0] r_col_r;
    logic [RW-1:0]  r_row_q;
    logic [RW-1:0]  r_row_r;

    // frame position
    logic [CW-1:0]  r_col_pos, n_col_pos;
    logic [RW-1:0]  r_row_pos, n_row_pos;
    logic [AW-1:0]  r_bin_col, n_bin_col;
    logic [RW-1:0]  r_band_row, n_band_row;
    logic [CW-1:0]  r_col_edge, n_col_edge;
    logic [DWW-1:0] r_col_rem, n_col_rem;
    logic [CW-1:0]  r_col_start, n_col_start;
    logic [RW-1:0]  r_row_edge, n_row_edge;
    logic [RW-1:0]  r_row_rem, n_row_rem;
    logic [RW-1:0]  r_band_start, n_band_start;

    // pending result
    logic [AW-1:0]  r_res_col;
    logic [RW-1:0]  r_res_row;
    logic           r_res_end;

    logic           r_out_valid;
    logic [PIX_W-1:0] r_avg_red, r_avg_green, r_avg_blue;
    logic [OUT_COL_W-1:0] r_out_col;
    logic [OUT_ROW_W-1:0] r_out_row;
    logic           r_frame_end;

    t_state r_state, n_state;

    logic cfg_we, cfg_hit, in_acc, bin_last, band_last, has_res, load_out;
    logic mem_wr;
    logic div_start, div_done;
    t_sums div_dvd;
    logic [CNT_W-1:0] div_dvs;
    logic [QW-1:0] div_quo [3];
    logic [CNT_W-1:0] div_rem0;
    t_sums mem_sum;
    t_pix pix;
    logic [CNT_W-1:0] bin_cnt;
    logic [CW:0]  col_step_e;
    logic [DWW:0] col_step_r;
    logic [RW:0]  row_step_e;
    logic [RW:0]  row_step_r;
    logic [CW-1:0] adv_col_edge;
    logic [DWW-1:0] adv_col_rem;
    logic [RW-1:0] adv_row_edge;
    logic [RW-1:0] adv_row_rem;

    assign cfg_we = i_cfg_valid & o_cfg_ready;
    // only a write to a known register restarts the frame
    assign cfg_hit = cfg_we & ((i_cfg_index == CFG_SRC_WIDTH) |
                               (i_cfg_index == CFG_SRC_HEIGHT) |
                               (i_cfg_index == CFG_DST_WIDTH) |
                               (i_cfg_index == CFG_DST_HEIGHT));
    assign in_acc = i_in_valid & o_in_ready;
    assign pix    = '{red: i_pix_red, green: i_pix_green, blue: i_pix_blue};

    // clamp so the image always shrinks and every bin holds a pixel
    always_comb begin
        int sw_i, sh_i, dw_i, dh_i, dwhi;
        sw_i = int'(r_src_width);
        sh_i = int'(r_src_height);
        dw_i = int'(r_dst_width);
        dh_i = int'(r_dst_height);
        if (sw_i < 2) sw_i = 2;
        if (sw_i > MAX_SRC_WIDTH) sw_i = MAX_SRC_WIDTH;
        if (sh_i < 2) sh_i = 2;
        if (sh_i > MAX_SRC_HEIGHT) sh_i = MAX_SRC_HEIGHT;
        dwhi = sw_i - 1;
        if (dwhi > MAX_DST_WIDTH) dwhi = MAX_DST_WIDTH;
        if (dw_i < 1) dw_i = 1;
        if (dw_i > dwhi) dw_i = dwhi;
        if (dh_i < 1) dh_i = 1;
        if (dh_i > sh_i - 1) dh_i = sh_i - 1;
        c_sw = CW'(sw_i);
        c_sh = RW'(sh_i);
        c_dw = DWW'(dw_i);
        c_dh = RW'(dh_i);
    end

    ads_sum_mem #(
        .DEPTH (MAX_DST_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rd_en (in_acc),
        .i_addr  (r_bin_col),
        .i_pix   (pix),
        .i_first (r_row_pos == r_band_start),
        .i_wr_en (mem_wr),
        .o_sum   (mem_sum)
    );

    ads_div #(
        .CNT_W (CNT_W),
        .QW    (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem0  (div_rem0)
    );

    assign bin_last  = (r_col_pos + 1'b1 == r_col_edge);
    assign band_last = (r_row_pos + 1'b1 == r_row_edge);
    assign has_res   = bin_last & band_last;
    assign bin_cnt   = CNT_W'(r_col_edge - r_col_start) * CNT_W'(r_row_edge - r_band_start);
    assign load_out  = (r_state == S_EMIT) & (~r_out_valid | i_out_ready);

    // next boundary: add the quotient, carry the remainder once
    assign col_step_r = {1'b0, r_col_rem} + {1'b0, r_col_r};
    assign col_step_e = {1'b0, r_col_edge} + {1'b0, r_col_q};
    always_comb begin
        if (col_step_r >= {1'b0, r_dw}) begin
            adv_col_rem  = DWW'(col_step_r - {1'b0, r_dw});
            adv_col_edge = CW'(col_step_e + 1'b1);
        end else begin
            adv_col_rem  = DWW'(col_step_r);
            adv_col_edge = CW'(col_step_e);
        end
    end
    assign row_step_r = {1'b0, r_row_rem} + {1'b0, r_row_r};
    assign row_step_e = {1'b0, r_row_edge} + {1'b0, r_row_q};
    always_comb begin
        if (row_step_r >= {1'b0, r_dh}) begin
            adv_row_rem  = RW'(row_step_r - {1'b0, r_dh});
            adv_row_edge = RW'(row_step_e + 1'b1);
        end else begin
            adv_row_rem  = RW'(row_step_r);
            adv_row_edge = RW'(row_step_e);
        end
    end

    // position advance after one pixel
    always_comb begin
        n_col_pos    = r_col_pos + 1'b1;
        n_row_pos    = r_row_pos;
        n_bin_col    = r_bin_col;
        n_band_row   = r_band_row;
        n_col_edge   = r_col_edge;
        n_col_rem    = r_col_rem;
        n_col_start  = r_col_start;
        n_row_edge   = r_row_edge;
        n_row_rem    = r_row_rem;
        n_band_start = r_band_start;
        if (bin_last) begin
            n_bin_col   = r_bin_col + 1'b1;
            n_col_start = r_col_edge;
            n_col_edge  = adv_col_edge;
            n_col_rem   = adv_col_rem;
        end
        if (r_col_pos + 1'b1 >= r_sw) begin
            n_col_pos   = '0;
            n_bin_col   = '0;
            n_col_start = '0;
            n_col_edge  = r_col_q;
            n_col_rem   = r_col_r;
            n_row_pos   = r_row_pos + 1'b1;
            if (r_row_pos + 1'b1 >= r_sh) begin
                n_row_pos    = '0;
                n_band_row   = '0;
                n_band_start = '0;
                n_row_edge   = r_row_q;
                n_row_rem    = r_row_r;
            end else if (band_last) begin
                n_band_start = r_row_edge;
                n_band_row   = r_band_row + 1'b1;
                n_row_edge   = adv_row_edge;
                n_row_rem    = adv_row_rem;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLAMP:  n_state = S_INIT_C;
            S_INIT_C: if (div_done) n_state = S_INIT_R;
            S_INIT_R: if (div_done) n_state = S_IDLE;
            S_IDLE:   if (in_acc) n_state = S_MOD;
            S_MOD:    n_state = has_res ? S_DIV : S_IDLE;
            S_DIV:    if (div_done) n_state = S_EMIT;
            S_EMIT:   if (load_out) n_state = S_IDLE;
            default:  n_state = S_CLAMP;
        endcase
        if (cfg_hit) n_state = S_CLAMP;
    end

    // control outputs
    always_comb begin
        o_cfg_ready = 1'b1;
        o_in_ready  = (r_state == S_IDLE);
        mem_wr      = (r_state == S_MOD);
        div_start   = 1'b0;
        div_dvd     = mem_sum;
        div_dvs     = bin_cnt;
        unique case (r_state)
            S_CLAMP: begin
                div_start = 1'b1;
                div_dvd   = '{red: SUM_W'(c_sw), green: '0, blue: '0};
                div_dvs   = CNT_W'(c_dw);
            end
            S_INIT_C: begin
                div_start = div_done;
                div_dvd   = '{red: SUM_W'(r_sh), green: '0, blue: '0};
                div_dvs   = CNT_W'(r_dh);
            end
            S_MOD: div_start = has_res;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLAMP;
            r_src_width  <= RST_SRC_WIDTH;
            r_src_height <= RST_SRC_HEIGHT;
            r_dst_width  <= RST_DST_WIDTH;
            r_dst_height <= RST_DST_HEIGHT;
            r_out_valid  <= 1'b0;
            r_col_pos    <= '0;
            r_row_pos    <= '0;
            r_bin_col    <= '0;
            r_band_row   <= '0;
            r_col_start  <= '0;
            r_band_start <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SRC_WIDTH:  r_src_width  <= SRC_W_BITS'(i_cfg_data);
                    CFG_SRC_HEIGHT: r_src_height <= SRC_H_BITS'(i_cfg_data);
                    CFG_DST_WIDTH:  r_dst_width  <= DST_W_BITS'(i_cfg_data);
                    CFG_DST_HEIGHT: r_dst_height <= DST_H_BITS'(i_cfg_data);
                    default: ;
                endcase
            end
            if (r_out_valid & i_out_ready) r_out_valid <= 1'b0;
            if (load_out) r_out_valid <= 1'b1;
            if (r_state == S_INIT_R && div_done) begin
                // restart frame at the top left pixel
                r_col_pos    <= '0;
                r_row_pos    <= '0;
                r_bin_col    <= '0;
                r_band_row   <= '0;
                r_col_start  <= '0;
                r_band_start <= '0;
            end else if (r_state == S_MOD) begin
                r_col_pos    <= n_col_pos;
                r_row_pos    <= n_row_pos;
                r_bin_col    <= n_bin_col;
                r_band_row   <= n_band_row;
                r_col_start  <= n_col_start;
                r_band_start <= n_band_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLAMP) begin
            r_sw <= c_sw;
            r_sh <= c_sh;
            r_dw <= c_dw;
            r_dh <= c_dh;
        end
        if (r_state == S_INIT_C && div_done) begin
            r_col_q <= CW'(div_quo[0]);
            r_col_r <= DWW'(div_rem0);
        end
        if (r_state == S_INIT_R && div_done) begin
            r_row_q    <= RW'(div_quo[0]);
            r_row_r    <= RW'(div_rem0);
            r_col_edge <= r_col_q;
            r_col_rem  <= r_col_r;
            r_row_edge <= RW'(div_quo[0]);
            r_row_rem  <= RW'(div_rem0);
        end else if (r_state == S_MOD) begin
            r_col_edge <= n_col_edge;
            r_col_rem  <= n_col_rem;
            r_row_edge <= n_row_edge;
            r_row_rem  <= n_row_rem;
        end
        if (r_state == S_MOD) begin
            r_res_col <= r_bin_col;
            r_res_row <= r_band_row;
            r_res_end <= (DWW'(r_bin_col) + 1'b1 == r_dw) && (r_band_row + 1'b1 == r_dh);
        end
        if (load_out) begin
            r_avg_red   <= div_quo[0][PIX_W-1:0];
            r_avg_green <= div_quo[1][PIX_W-1:0];
            r_avg_blue  <= div_quo[2][PIX_W-1:0];
            r_out_col   <= OUT_COL_W'(r_res_col);
            r_out_row   <= OUT_ROW_W'(r_res_row);
            r_frame_end <= r_res_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_avg_red   = r_avg_red;
    assign o_avg_green = r_avg_green;
    assign o_avg_blue  = r_avg_blue;
    assign o_out_col   = r_out_col;
    assign o_out_row   = r_out_row;
    assign o_frame_end = r_frame_end;

    a_mod_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> $past(in_acc))
        else $error("write-back without an accepted word");

    a_div_done_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV || r_state == S_INIT_C || r_state == S_INIT_R ||
                      r_state == S_CLAMP))
        else $error("divider finished with no consumer");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_col_pos < r_sw && r_col_pos < r_col_edge))
        else $error("column position outside frame or bin");

    a_band_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_row_pos < r_row_edge && r_row_pos >= r_band_start))
        else $error("row position outside its band");

endmodule

@@ dv/ads_avg_checker.sv @@
// Checker for the area-average downscaler: watches the config, pixel and result
// channels, predicts each averaged pixel and compares. Depends on ads_pkg.
`timescale 1ns / 100ps
module ads_avg_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ads_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ads_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [ads_pkg::PIX_W-1:0]      i_pix_red,
    input  logic [ads_pkg::PIX_W-1:0]      i_pix_green,
    input  logic [ads_pkg::PIX_W-1:0]      i_pix_blue,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [ads_pkg::PIX_W-1:0]      i_avg_red,
    input  logic [ads_pkg::PIX_W-1:0]      i_avg_green,
    input  logic [ads_pkg::PIX_W-1:0]      i_avg_blue,
    input  logic [ads_pkg::OUT_COL_W-1:0]  i_out_col,
    input  logic [ads_pkg::OUT_ROW_W-1:0]  i_out_row,
    input  logic                           i_frame_end,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_results,
    output int                             o_pixels
);
    import ads_pkg::*;

    localparam int MAX_SW = DEF_MAX_SRC_WIDTH;
    localparam int MAX_SH = DEF_MAX_SRC_HEIGHT;
    localparam int MAX_DW = DEF_MAX_DST_WIDTH;

    typedef struct {
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic                 last;
    } t_avg_pix;

    t_avg_pix avg_queue[$];

    logic [SRC_W_BITS-1:0] sw_reg;
    logic [SRC_H_BITS-1:0] sh_reg;
    logic [DST_W_BITS-1:0] dw_reg;
    logic [DST_H_BITS-1:0] dh_reg;

    logic [SUM_W-1:0] red_acc   [MAX_DW];
    logic [SUM_W-1:0] green_acc [MAX_DW];
    logic [SUM_W-1:0] blue_acc  [MAX_DW];
    int unsigned col_pos, row_pos, bin_idx, band_idx, col_bound, row_bound, band_top;

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned eff_sw();
        return clip(sw_reg, 2, MAX_SW);
    endfunction

    function automatic int unsigned eff_sh();
        return clip(sh_reg, 2, MAX_SH);
    endfunction

    function automatic int unsigned eff_dw();
        int unsigned hi;
        hi = eff_sw() - 1;
        if (hi > MAX_DW) hi = MAX_DW;
        return clip(dw_reg, 1, hi);
    endfunction

    function automatic int unsigned eff_dh();
        return clip(dh_reg, 1, eff_sh() - 1);
    endfunction

    function automatic int unsigned boundary(int unsigned i, int unsigned s, int unsigned d);
        longint unsigned p;
        p = longint'(i) * longint'(s);
        return int'(p / d);
    endfunction

    task automatic restart_frame();
        col_pos   = 0;
        row_pos   = 0;
        bin_idx   = 0;
        band_idx  = 0;
        band_top  = 0;
        col_bound = boundary(1, eff_sw(), eff_dw());
        row_bound = boundary(1, eff_sh(), eff_dh());
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    // Accumulate one source pixel and queue the averaged pixel it completes.
    task automatic accumulate_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                    logic [PIX_W-1:0] b);
        int unsigned sw, sh, dw, dh, k, c0;
        longint unsigned cnt;
        bit bin_done, band_done;
        t_avg_pix e;
        sw = eff_sw();
        sh = eff_sh();
        dw = eff_dw();
        dh = eff_dh();
        k = (bin_idx >= MAX_DW) ? MAX_DW - 1 : bin_idx;
        if (row_pos == band_top) begin
            red_acc[k]   = r;
            green_acc[k] = g;
            blue_acc[k]  = b;
        end else begin
            red_acc[k]   += r;
            green_acc[k] += g;
            blue_acc[k]  += b;
        end
        bin_done  = (col_pos + 1 == col_bound);
        band_done = (row_pos + 1 == row_bound);
        if (bin_done && band_done) begin
            c0  = boundary(bin_idx, sw, dw);
            cnt = longint'(col_bound - c0) * longint'(row_bound - band_top);
            if (cnt == 0) cnt = 1;
            e.red   = PIX_W'(longint'(red_acc[k]) / cnt);
            e.green = PIX_W'(longint'(green_acc[k]) / cnt);
            e.blue  = PIX_W'(longint'(blue_acc[k]) / cnt);
            e.col   = OUT_COL_W'(bin_idx);
            e.row   = OUT_ROW_W'(band_idx);
            e.last  = (bin_idx + 1 == dw) && (band_idx + 1 == dh);
            avg_queue.push_back(e);
        end
        if (bin_done) begin
            bin_idx++;
            col_bound = boundary(bin_idx + 1, sw, dw);
        end
        col_pos++;
        if (col_pos >= sw) begin
            col_pos   = 0;
            bin_idx   = 0;
            col_bound = boundary(1, sw, dw);
            row_pos++;
            if (row_pos >= sh) begin
                row_pos   = 0;
                band_idx  = 0;
                band_top  = 0;
                row_bound = boundary(1, sh, dh);
            end else if (row_pos >= row_bound) begin
                band_top = row_pos;
                band_idx++;
                row_bound = boundary(band_idx + 1, sh, dh);
            end
        end
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_pixels  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_avg_pix e;
        if (!i_rst_n) begin
            sw_reg = RST_SRC_WIDTH;
            sh_reg = RST_SRC_HEIGHT;
            dw_reg = RST_DST_WIDTH;
            dh_reg = RST_DST_HEIGHT;
            avg_queue.delete();
            restart_frame();
        end else begin
            // retire the result word before the pixel taken at the same edge
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (avg_queue.size() == 0) begin
                    $display("%0t: result word at col %0d row %0d with none expected",
                             $time, i_out_col, i_out_row);
                    o_errors++;
                end else begin
                    e = avg_queue.pop_front();
                    if (i_avg_red !== e.red)     report_mismatch("avg_red", i_avg_red, e.red);
                    if (i_avg_green !== e.green) report_mismatch("avg_green", i_avg_green, e.green);
                    if (i_avg_blue !== e.blue)   report_mismatch("avg_blue", i_avg_blue, e.blue);
                    if (i_out_col !== e.col)     report_mismatch("out_col", i_out_col, e.col);
                    if (i_out_row !== e.row)     report_mismatch("out_row", i_out_row, e.row);
                    if (i_frame_end !== e.last)  report_mismatch("frame_end", i_frame_end, e.last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SRC_WIDTH: begin
                        sw_reg = i_cfg_data;
                        restart_frame();
                    end
                    CFG_SRC_HEIGHT: begin
                        sh_reg = i_cfg_data;
                        restart_frame();
                    end
                    CFG_DST_WIDTH: begin
                        dw_reg = DST_W_BITS'(i_cfg_data);
                        restart_frame();
                    end
                    CFG_DST_HEIGHT: begin
                        dh_reg = DST_H_BITS'(i_cfg_data);
                        restart_frame();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                o_pixels++;
                accumulate_pixel(i_pix_red, i_pix_green, i_pix_blue);
            end
        end
        o_pending = avg_queue.size();
    end

endmodule

@@ dv/area_average_downscaler_tb.sv @@
// Testbench top for the area-average downscaler: clock, reset, pixel and config
// stimulus with random gaps, result back-pressure. Depends on ads_pkg, ads_avg_checker.
`timescale 1ns / 100ps
module area_average_downscaler_tb;
    import ads_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;
    localparam int PIXEL_TARGET = 650;
    localparam int SETTLE_CYCLES = 120;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic [PIX_W-1:0] i_pix_red, i_pix_green, i_pix_blue;
    logic o_out_valid;
    logic i_out_ready;
    logic [PIX_W-1:0] o_avg_red, o_avg_green, o_avg_blue;
    logic [OUT_COL_W-1:0] o_out_col;
    logic [OUT_ROW_W-1:0] o_out_row;
    logic o_frame_end;

    int errors, pending, results, pixels;
    int phases;
    bit no_gaps;

    area_average_downscaler dut (.*);

    ads_avg_checker checker_i (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_pix_red, .i_pix_green, .i_pix_blue,
        .i_out_valid(o_out_valid), .i_out_ready, .i_avg_red(o_avg_red),
        .i_avg_green(o_avg_green), .i_avg_blue(o_avg_blue), .i_out_col(o_out_col),
        .i_out_row(o_out_row), .i_frame_end(o_frame_end),
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_pixels(pixels)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #3_000_000;
        $display("timeout with %0d result words outstanding", pending);
        $display("simulation failed");
        $finish;
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 11);
    endfunction

    // Result side: stall a random number of cycles, then hold ready until a word moves.
    initial begin
        int n;
        bit moved;
        i_out_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do begin
                @(negedge i_clk);
                moved = o_out_valid && i_out_ready;
                @(posedge i_clk);
            end while (!moved);
        end
    end

    task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
        int n;
        bit taken;
        n = draw_gap();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pix_red   <= r;
        i_pix_green <= g;
        i_pix_blue  <= b;
        do begin
            @(negedge i_clk);
            taken = i_in_valid && o_in_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        int n;
        bit taken;
        i_in_valid <= 1'b0;
        n = draw_gap();
        if (n > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            taken = i_cfg_valid && o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain every expected word, then let a pixel still in flight finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(int sw, int sh, int dw, int dh);
        drain();
        write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(sw));
        write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(sh));
        write_reg(CFG_DST_WIDTH, CFG_DATA_W'(dw));
        write_reg(CFG_DST_HEIGHT, CFG_DATA_W'(dh));
        phases++;
    endtask

    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int sw, sh, dw, dh, n;
        bit odd;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_pix_red   = '0;
        i_pix_green = '0;
        i_pix_blue  = '0;
        no_gaps     = 1'b0;
        phases      = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: a few pixels of the first band, no words yet
        send_pixel('0, '1, '0);
        send_pixel('1, '0, '1);
        // zero everywhere clamps to a 2x2 source and a single bin
        set_dims(0, 0, 0, 0);
        repeat (4) send_pixel('1, '1, '1);
        repeat (4) send_pixel('0, '0, '0);
        // all ones: clamps to the largest source and widest destination
        set_dims(8191, 8191, 8191, 8191);
        repeat (4) send_pixel(8'hA5, 8'h5A, 8'hC3);
        // unused index must leave the partial frame alone
        drain();
        write_reg(CFG_UNUSED, '1);
        send_pixel(8'h3C, 8'hF0, 8'h0F);
        // 3 -> 2 in both directions gives uneven bins
        set_dims(3, 3, 2, 2);
        repeat (9) send_pixel(rand_chan(), rand_chan(), rand_chan());

        while (pixels < PIXEL_TARGET) begin
            odd = ($urandom_range(0, 4) == 0);
            sw = $urandom_range(2, 12);
            sh = $urandom_range(2, 8);
            dw = odd ? $urandom_range(0, 2047) : $urandom_range(1, sw - 1);
            dh = odd ? $urandom_range(0, 4095) : $urandom_range(1, sh - 1);
            no_gaps = ($urandom_range(0, 3) == 0);
            set_dims(sw, sh, dw, dh);
            n = sw * sh * $urandom_range(1, 2) + $urandom_range(0, 3);
            repeat (n) send_pixel(rand_chan(), rand_chan(), rand_chan());
        end
        drain();

        $display("%0d pixels over %0d geometries, %0d averaged words checked",
                 pixels, phases, results);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
